[hw/rtl/ilc_pkg.sv]
`default_nettype none

package ilc_pkg;

	// Character codes used by the automata
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_F  = 8'h46;
	localparam logic [7:0] CH_LC_X  = 8'h78;
	localparam logic [7:0] CH_UC_X  = 8'h58;
	localparam logic [7:0] CH_LC_U  = 8'h75;
	localparam logic [7:0] CH_UC_U  = 8'h55;
	localparam logic [7:0] CH_LC_L  = 8'h6C;
	localparam logic [7:0] CH_UC_L  = 8'h4C;

	// Token classification reported on the last character
	typedef enum logic [2:0] {
		KIND_BAD_CHARS  = 3'd0,
		KIND_DEC        = 3'd1,
		KIND_DEC_SUFFIX = 3'd2,
		KIND_HEX        = 3'd3,
		KIND_HEX_SUFFIX = 3'd4,
		KIND_OCT        = 3'd5,
		KIND_OCT_SUFFIX = 3'd6,
		KIND_NONE       = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		DEC_START  = 3'd0,
		DEC_SIGN   = 3'd1,
		DEC_DIGITS = 3'd2,
		DEC_U      = 3'd3,
		DEC_L      = 3'd4,
		DEC_UL     = 3'd5,
		DEC_REJECT = 3'd6
	} dec_state_t;

	typedef enum logic [3:0] {
		HEX_START  = 4'd0,
		HEX_SIGN   = 4'd1,
		HEX_ZERO   = 4'd2,
		HEX_PREFIX = 4'd3,
		HEX_DIGITS = 4'd4,
		HEX_U      = 4'd5,
		HEX_L      = 4'd6,
		HEX_UL     = 4'd7,
		HEX_REJECT = 4'd8
	} hex_state_t;

	typedef enum logic [2:0] {
		OCT_START  = 3'd0,
		OCT_SIGN   = 3'd1,
		OCT_ZERO   = 3'd2,
		OCT_DIGITS = 3'd3,
		OCT_U      = 3'd4,
		OCT_L      = 3'd5,
		OCT_UL     = 3'd6,
		OCT_REJECT = 3'd7
	} oct_state_t;

	// Scanner step control handed from the pipeline to the automata
	typedef struct packed {
		logic en;
		logic last;
	} step_t;

	function automatic logic is_u(input logic [7:0] c);
		return (c == CH_LC_U) || (c == CH_UC_U);
	endfunction

	function automatic logic is_l(input logic [7:0] c);
		return (c == CH_LC_L) || (c == CH_UC_L);
	endfunction

	function automatic logic is_sign(input logic [7:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic in_alphabet(input logic [7:0] c);
		return is_digit(c) || is_sign(c) ||
			((c >= CH_LC_A) && (c <= CH_LC_F)) || ((c >= CH_UC_A) && (c <= CH_UC_F)) ||
			(c == CH_LC_X) || (c == CH_UC_X) || is_u(c) || is_l(c);
	endfunction

	// Decimal automaton: no leading zero, then optional u/l suffix pair
	function automatic dec_state_t dec_next(input dec_state_t s, input logic [7:0] c);
		dec_state_t n;
		n = DEC_REJECT;
		unique case (s)
			DEC_START: begin
				if (is_digit(c) && (c != CH_ZERO)) n = DEC_DIGITS;
				else if (is_sign(c)) n = DEC_SIGN;
			end
			DEC_SIGN: begin
				if (is_digit(c) && (c != CH_ZERO)) n = DEC_DIGITS;
			end
			DEC_DIGITS: begin
				if (is_digit(c)) n = DEC_DIGITS;
				else if (is_u(c)) n = DEC_U;
				else if (is_l(c)) n = DEC_L;
			end
			DEC_U: begin
				if (is_l(c)) n = DEC_UL;
			end
			DEC_L: begin
				if (is_u(c)) n = DEC_UL;
			end
			DEC_UL, DEC_REJECT: n = DEC_REJECT;
			default: n = DEC_REJECT;
		endcase
		return n;
	endfunction

	// Hex automaton: any byte outside x/u/l/sign/0 counts as a hex digit
	function automatic hex_state_t hex_next(input hex_state_t s, input logic [7:0] c);
		logic is_x;
		logic is_other;
		hex_state_t n;
		is_x = (c == CH_LC_X) || (c == CH_UC_X);
		is_other = !is_x && !is_u(c) && !is_l(c) && !is_sign(c) && (c != CH_ZERO);
		n = HEX_REJECT;
		unique case (s)
			HEX_START: begin
				if (is_sign(c)) n = HEX_SIGN;
				else if (c == CH_ZERO) n = HEX_ZERO;
			end
			HEX_SIGN: begin
				if (c == CH_ZERO) n = HEX_ZERO;
			end
			HEX_ZERO: begin
				if (is_x) n = HEX_PREFIX;
			end
			HEX_PREFIX: begin
				if (is_other || (c == CH_ZERO)) n = HEX_DIGITS;
			end
			HEX_DIGITS: begin
				if (is_other || (c == CH_ZERO)) n = HEX_DIGITS;
				else if (is_u(c)) n = HEX_U;
				else if (is_l(c)) n = HEX_L;
			end
			HEX_U: begin
				if (is_l(c)) n = HEX_UL;
			end
			HEX_L: begin
				if (is_u(c)) n = HEX_UL;
			end
			HEX_UL, HEX_REJECT: n = HEX_REJECT;
			default: n = HEX_REJECT;
		endcase
		return n;
	endfunction

	// Octal automaton: leading 0, then digits 0-7, then optional suffix pair
	function automatic oct_state_t oct_next(input oct_state_t s, input logic [7:0] c);
		logic is_oct;
		oct_state_t n;
		is_oct = (c >= CH_ZERO) && (c <= CH_SEVEN);
		n = OCT_REJECT;
		unique case (s)
			OCT_START: begin
				if (is_sign(c)) n = OCT_SIGN;
				else if (c == CH_ZERO) n = OCT_ZERO;
			end
			OCT_SIGN: begin
				if (c == CH_ZERO) n = OCT_ZERO;
			end
			OCT_ZERO: begin
				if (is_oct) n = OCT_DIGITS;
			end
			OCT_DIGITS: begin
				if (is_oct) n = OCT_DIGITS;
				else if (is_u(c)) n = OCT_U;
				else if (is_l(c)) n = OCT_L;
			end
			OCT_U: begin
				if (is_l(c)) n = OCT_UL;
			end
			OCT_L: begin
				if (is_u(c)) n = OCT_UL;
			end
			OCT_UL, OCT_REJECT: n = OCT_REJECT;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/ilc_automata.sv]
`default_nettype none

module ilc_automata import ilc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire step_t      step,
	input  wire logic [7:0] ch,
	output kind_t           kind
);

	dec_state_t dec_state_q, dec_state_d;
	hex_state_t hex_state_q, hex_state_d;
	oct_state_t oct_state_q, oct_state_d;
	logic       bad_seen_q, bad_seen_d;

	// One table step per character for each automaton
	always_comb begin
		dec_state_d = dec_next(dec_state_q, ch);
		hex_state_d = hex_next(hex_state_q, ch);
		oct_state_d = oct_next(oct_state_q, ch);
		bad_seen_d  = bad_seen_q || !in_alphabet(ch);
	end

	// Classification from the post-step states, in priority order
	always_comb begin
		priority if (bad_seen_d) kind = KIND_BAD_CHARS;
		else if (dec_state_d == DEC_DIGITS) kind = KIND_DEC;
		else if ((dec_state_d == DEC_U) || (dec_state_d == DEC_L) ||
			(dec_state_d == DEC_UL)) kind = KIND_DEC_SUFFIX;
		else if ((hex_state_d == HEX_PREFIX) || (hex_state_d == HEX_DIGITS)) kind = KIND_HEX;
		else if ((hex_state_d == HEX_U) || (hex_state_d == HEX_L) ||
			(hex_state_d == HEX_UL)) kind = KIND_HEX_SUFFIX;
		else if ((oct_state_d == OCT_ZERO) || (oct_state_d == OCT_DIGITS)) kind = KIND_OCT;
		else if ((oct_state_d == OCT_U) || (oct_state_d == OCT_L) ||
			(oct_state_d == OCT_UL)) kind = KIND_OCT_SUFFIX;
		else kind = KIND_NONE;
	end

	// State registers: step on every character, back to start after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_state_q <= DEC_START;
			hex_state_q <= HEX_START;
			oct_state_q <= OCT_START;
			bad_seen_q  <= 1'b0;
		end else if (step.en) begin
			if (step.last) begin
				dec_state_q <= DEC_START;
				hex_state_q <= HEX_START;
				oct_state_q <= OCT_START;
				bad_seen_q  <= 1'b0;
			end else begin
				dec_state_q <= dec_state_d;
				hex_state_q <= hex_state_d;
				oct_state_q <= oct_state_d;
				bad_seen_q  <= bad_seen_d;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/integer_literal_classifier_core.sv]
`default_nettype none

// Integer literal classifier. Feed the characters of a token one byte per beat
// on ch, with last set on the final character; one beat on the result channel
// follows each token, carrying kind (0 invalid characters, 1/2 decimal without/
// with u-l suffix, 3/4 hex, 5/6 octal, 7 not an integer constant). Characters
// are taken at one per cycle unless a last character waits for a free result slot:
// each beat passes an input register, then a single table step of the decimal,
// hex and octal automata plus the alphabet check, and the state registers close
// that loop. The result register is loaded as the last character leaves the input
// register, once the result slot is free; that edge also returns the scanner
// state to start, so the next token can follow with no gap. The result register
// lets the scanner consume characters of the next token while a result waits.

module integer_literal_classifier_core import ilc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] ch,
	input  wire logic       last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      kind
);

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       last_s1;
	logic       out_valid_q;
	kind_t      kind_q;
	kind_t      kind_c;
	logic       out_free;
	logic       advance;
	step_t      step;

	// Flow control: a non-last beat always steps, a last beat needs a free result slot
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || advance;

	assign step.en   = advance;
	assign step.last = last_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	ilc_automata u_automata (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.ch     (ch_s1),
		.kind   (kind_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			kind_q <= kind_c;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;

endmodule

`default_nettype wire

[hw/rtl/ilc_checker.sv]
`default_nettype none

module ilc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [7:0] ch,
	input wire logic       last,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] kind
);

	logic in_beat;
	logic in_last_beat;

	assign in_beat      = in_valid && in_ready;
	assign in_last_beat = in_beat && last && (ch == ch);

	// A stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind))
		else $error("result changed or dropped while stalled");

	// The input side only backs up behind a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a stalled result");

	// A fresh result must follow an accepted last character
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_last_beat, 2))
		else $error("result without a matching last character");

endmodule

bind integer_literal_classifier_core ilc_checker u_ilc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.ch        (ch),
	.last      (last),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.kind      (kind)
);

`default_nettype wire
